// ===== rtl/ffa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffa_pkg: shared types and constants of the first-fit heap allocator
// Holds the block table entry, the RAM access bundle and the status codes.
// ----------------------------------------------------------------------------
package ffa_pkg;

    localparam int HEAP_BYTES   = 65536;
    localparam int MAX_BLOCKS   = 64;
    localparam int HEADER_BYTES = 32;

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = IDX_W + 1;
    localparam int OFS_W = 17;
    localparam int ENTRY_W = 2 * OFS_W + 1;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NOP     = 3'd1;
    localparam logic [2:0] ST_NO_HEAP = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_UNKNOWN = 3'd4;

    typedef struct packed {
        logic [OFS_W-1:0] offset;
        logic [OFS_W-1:0] length;
        logic             is_free;
    } entry_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        entry_t           wdata;
        logic [IDX_W-1:0] raddr;
    } ram_req_t;

    typedef struct packed {
        logic [15:0] address;
        logic [2:0]  status;
    } result_t;

endpackage

// ===== rtl/ffa_ram.sv =====
// ----------------------------------------------------------------------------
// ffa_ram: simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/ffa_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffa_ctrl: allocator sequencer
// Scans the block table in RAM, splits, merges and shifts entries.
// ----------------------------------------------------------------------------
module ffa_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       operation,
    input  logic [16:0]                request_size,
    input  logic [15:0]                payload_address,
    input  logic [ffa_pkg::OFS_W-1:0]  limit,
    input  logic                       rsp_free,
    input  ffa_pkg::entry_t            rdata,
    output ffa_pkg::ram_req_t          ram,
    output logic                       busy,
    output logic                       done,
    output ffa_pkg::result_t           result
);

    localparam int CW = ffa_pkg::CNT_W;
    localparam int IW = ffa_pkg::IDX_W;
    localparam int OW = ffa_pkg::OFS_W;

    typedef enum logic [13:0] {
        S_IDLE     = 14'b00000000000001,
        S_SCAN_RD  = 14'b00000000000010,
        S_SCAN_CHK = 14'b00000000000100,
        S_SUP_RD   = 14'b00000000001000,
        S_SUP_WR   = 14'b00000000010000,
        S_UPD1     = 14'b00000000100000,
        S_UPD2     = 14'b00000001000000,
        S_NEXT_RD  = 14'b00000010000000,
        S_NEXT_CHK = 14'b00000100000000,
        S_PREV_MRG = 14'b00001000000000,
        S_SDN_RD   = 14'b00010000000000,
        S_SDN_WR   = 14'b00100000000000,
        S_GROW     = 14'b01000000000000,
        S_RESP     = 14'b10000000000000
    } state_t;

    state_t            state_reg, state_next;
    logic              op_reg, op_next;
    logic [16:0]       size_reg, size_next;
    logic [15:0]       paddr_reg, paddr_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [OW-1:0]     top_reg, top_next;
    logic [CW-1:0]     k_reg, k_next;
    logic [1:0]        d_reg, d_next;
    ffa_pkg::entry_t   cur_reg, cur_next;
    ffa_pkg::entry_t   prev_reg, prev_next;
    ffa_pkg::entry_t   aux_reg, aux_next;
    ffa_pkg::result_t  res_reg, res_next;

    logic [OW:0]       hdr_size;
    logic [OW:0]       ofs_hdr;
    logic              alloc_hit;
    logic              free_hit;
    logic              split;
    logic [OW+1:0]     grow_end;

    assign hdr_size  = (OW+1)'(ffa_pkg::HEADER_BYTES) + {1'b0, size_reg};
    assign ofs_hdr   = {1'b0, rdata.offset} + (OW+1)'(ffa_pkg::HEADER_BYTES);
    assign alloc_hit = rdata.is_free && (rdata.length >= size_reg);
    assign free_hit  = (ofs_hdr == {2'b00, paddr_reg});
    assign split     = ({1'b0, rdata.length} > hdr_size)
                       && (cnt_reg < CW'(ffa_pkg::MAX_BLOCKS));
    assign grow_end  = {2'b00, top_reg} + {1'b0, hdr_size};

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        size_next  = size_reg;
        paddr_next = paddr_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        top_next   = top_reg;
        k_next     = k_reg;
        d_next     = d_reg;
        cur_next   = cur_reg;
        prev_next  = prev_reg;
        aux_next   = aux_reg;
        res_next   = res_reg;
        ram        = '0;
        done       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = operation;
                    size_next  = request_size;
                    paddr_next = payload_address;
                    idx_next   = '0;
                    res_next   = '0;
                    if ((operation == ffa_pkg::OP_ALLOC && request_size == '0) ||
                        (operation == ffa_pkg::OP_FREE && payload_address == '0))
                    begin
                        res_next.status = ffa_pkg::ST_NOP;
                        state_next = S_RESP;
                    end
                    else if (cnt_reg == '0)
                    begin
                        state_next = S_GROW;
                    end
                    else
                    begin
                        state_next = S_SCAN_RD;
                    end
                end
            end

            S_SCAN_RD:
            begin
                ram.raddr  = idx_reg[IW-1:0];
                state_next = S_SCAN_CHK;
            end

            S_SCAN_CHK:
            begin
                if (op_reg == ffa_pkg::OP_ALLOC && alloc_hit)
                begin
                    res_next.address = ofs_hdr[15:0];
                    res_next.status  = ffa_pkg::ST_OK;
                    if (split)
                    begin
                        cur_next.offset  = rdata.offset;
                        cur_next.length  = size_reg;
                        cur_next.is_free = 1'b0;
                        aux_next.offset  = OW'(ofs_hdr + {1'b0, size_reg});
                        aux_next.length  = OW'({1'b0, rdata.length} - hdr_size);
                        aux_next.is_free = 1'b1;
                        k_next = cnt_reg;
                        if (cnt_reg > idx_reg + CW'(1))
                            state_next = S_SUP_RD;
                        else
                            state_next = S_UPD1;
                    end
                    else
                    begin
                        ram.we            = 1'b1;
                        ram.waddr         = idx_reg[IW-1:0];
                        ram.wdata         = rdata;
                        ram.wdata.is_free = 1'b0;
                        state_next        = S_RESP;
                    end
                end
                else if (op_reg == ffa_pkg::OP_FREE && free_hit)
                begin
                    cur_next         = rdata;
                    cur_next.is_free = 1'b1;
                    d_next           = 2'd0;
                    if (idx_reg + CW'(1) < cnt_reg)
                        state_next = S_NEXT_RD;
                    else
                        state_next = S_PREV_MRG;
                end
                else
                begin
                    prev_next = rdata;
                    idx_next  = idx_reg + CW'(1);
                    if (idx_reg + CW'(1) >= cnt_reg)
                        state_next = S_GROW;
                    else
                        state_next = S_SCAN_RD;
                end
            end

            // open a hole at idx+1: move entries up by one, top first
            S_SUP_RD:
            begin
                ram.raddr  = IW'(k_reg - CW'(1));
                state_next = S_SUP_WR;
            end

            S_SUP_WR:
            begin
                ram.we    = 1'b1;
                ram.waddr = k_reg[IW-1:0];
                ram.wdata = rdata;
                k_next    = k_reg - CW'(1);
                if (k_reg - CW'(1) > idx_reg + CW'(1))
                    state_next = S_SUP_RD;
                else
                    state_next = S_UPD1;
            end

            S_UPD1:
            begin
                ram.we     = 1'b1;
                ram.waddr  = IW'(idx_reg + CW'(1));
                ram.wdata  = aux_reg;
                state_next = S_UPD2;
            end

            S_UPD2:
            begin
                ram.we     = 1'b1;
                ram.waddr  = idx_reg[IW-1:0];
                ram.wdata  = cur_reg;
                cnt_next   = cnt_reg + CW'(1);
                state_next = S_RESP;
            end

            S_NEXT_RD:
            begin
                ram.raddr  = IW'(idx_reg + CW'(1));
                state_next = S_NEXT_CHK;
            end

            S_NEXT_CHK:
            begin
                if (rdata.is_free)
                begin
                    cur_next.length = cur_reg.length + rdata.length
                                      + OW'(ffa_pkg::HEADER_BYTES);
                    d_next = 2'd1;
                end
                state_next = S_PREV_MRG;
            end

            S_PREV_MRG:
            begin
                ram.we    = 1'b1;
                ram.wdata = cur_reg;
                ram.waddr = idx_reg[IW-1:0];
                k_next    = idx_reg + CW'(1);
                d_next    = d_reg;
                if (idx_reg != '0 && prev_reg.is_free)
                begin
                    ram.waddr = IW'(idx_reg - CW'(1));
                    ram.wdata.offset = prev_reg.offset;
                    ram.wdata.length = prev_reg.length + cur_reg.length
                                       + OW'(ffa_pkg::HEADER_BYTES);
                    k_next = idx_reg;
                    d_next = d_reg + 2'd1;
                end
                cnt_next = cnt_reg - CW'(d_next);
                res_next.status = ffa_pkg::ST_OK;
                if (d_next != 2'd0 && k_next < cnt_reg - CW'(d_next))
                    state_next = S_SDN_RD;
                else
                    state_next = S_RESP;
            end

            // close the gap: move entries down by d, bottom first
            S_SDN_RD:
            begin
                ram.raddr  = IW'(k_reg + CW'(d_reg));
                state_next = S_SDN_WR;
            end

            S_SDN_WR:
            begin
                ram.we    = 1'b1;
                ram.waddr = k_reg[IW-1:0];
                ram.wdata = rdata;
                k_next    = k_reg + CW'(1);
                if (k_reg + CW'(1) < cnt_reg)
                    state_next = S_SDN_RD;
                else
                    state_next = S_RESP;
            end

            S_GROW:
            begin
                if (op_reg == ffa_pkg::OP_FREE)
                begin
                    res_next.status = ffa_pkg::ST_UNKNOWN;
                end
                else if (grow_end > {2'b00, limit})
                begin
                    res_next.status = ffa_pkg::ST_NO_HEAP;
                end
                else if (cnt_reg >= CW'(ffa_pkg::MAX_BLOCKS))
                begin
                    res_next.status = ffa_pkg::ST_FULL;
                end
                else
                begin
                    ram.we            = 1'b1;
                    ram.waddr         = cnt_reg[IW-1:0];
                    ram.wdata.offset  = top_reg;
                    ram.wdata.length  = size_reg;
                    ram.wdata.is_free = 1'b0;
                    cnt_next          = cnt_reg + CW'(1);
                    top_next          = OW'(grow_end);
                    res_next.address  = 16'(top_reg + OW'(ffa_pkg::HEADER_BYTES));
                    res_next.status   = ffa_pkg::ST_OK;
                end
                state_next = S_RESP;
            end

            S_RESP:
            begin
                if (rsp_free)
                begin
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            top_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            top_reg   <= top_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        size_reg  <= size_next;
        paddr_reg <= paddr_next;
        idx_reg   <= idx_next;
        k_reg     <= k_next;
        d_reg     <= d_next;
        cur_reg   <= cur_next;
        prev_reg  <= prev_next;
        aux_reg   <= aux_next;
        res_reg   <= res_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign result = res_reg;

endmodule

// ===== rtl/first_fit_heap_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_heap_allocator: first-fit heap allocator with coalescing
// Keeps an address-ordered block table in RAM and serves allocate and free
// requests one at a time.
// ----------------------------------------------------------------------------
// One request is in flight at a time. A request reads and checks each table
// entry visited by the first-fit or address scan, then reads and writes each
// entry moved when a split opens a slot or a merge closes one, and ends with
// bookkeeping states. A scan and the moves that follow it never cover more
// than the table once; the work per entry is set by the single read and
// single write port of the block table RAM. Null frees and zero-size
// allocates skip the scan and go straight to the response state. The result
// sits in an output register, so a new request is taken while the previous
// result still waits. Write heap_limit only while idle.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator (
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        req_valid,
    output logic        req_stall,
    input  logic        operation,
    input  logic [16:0] request_size,
    input  logic [15:0] payload_address,
    // result channel
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [15:0] result_address,
    output logic [2:0]  status,
    // configuration write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [16:0] heap_limit
);

    logic                    busy;
    logic                    done;
    logic                    accept;
    logic                    rsp_free;
    ffa_pkg::ram_req_t       ram;
    ffa_pkg::entry_t         rdata;
    ffa_pkg::result_t        result;
    logic [16:0]             limit_reg;
    logic [16:0]             limit_eff;
    logic                    rsp_valid_reg;
    ffa_pkg::result_t        rsp_reg;

    // hold off new requests while the sequencer works
    assign req_stall = busy;
    assign accept    = req_valid && !busy;
    assign cfg_ready = 1'b1;

    // clamp the growth limit to the heap size
    assign limit_eff = (limit_reg < 17'(ffa_pkg::HEAP_BYTES))
                       ? limit_reg : 17'(ffa_pkg::HEAP_BYTES);

    // the output register is free when empty or being drained
    assign rsp_free = !rsp_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= 17'h10000;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= heap_limit;
            end
            if (done)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // load the result payload on completion
    always_ff @(posedge clk)
    begin
        if (done)
        begin
            rsp_reg <= result;
        end
    end

    assign rsp_valid      = rsp_valid_reg;
    assign result_address = rsp_reg.address;
    assign status         = rsp_reg.status;

    ffa_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (accept),
        .operation       (operation),
        .request_size    (request_size),
        .payload_address (payload_address),
        .limit           (limit_eff),
        .rsp_free        (rsp_free),
        .rdata           (rdata),
        .ram             (ram),
        .busy            (busy),
        .done            (done),
        .result          (result)
    );

    // block table: offset, length and free mark per entry
    ffa_ram #(
        .WIDTH (ffa_pkg::ENTRY_W),
        .DEPTH (ffa_pkg::MAX_BLOCKS)
    ) u_table (
        .clk   (clk),
        .we    (ram.we),
        .waddr (ram.waddr),
        .wdata (ram.wdata),
        .raddr (ram.raddr),
        .rdata (rdata)
    );

endmodule

// ===== rtl/ffa_checker.sv =====
// ----------------------------------------------------------------------------
// ffa_checker: port-level checks of the allocator
// Watches the request and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module ffa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_stall,
    input logic        rsp_valid,
    input logic        rsp_stall,
    input logic [15:0] result_address,
    input logic [2:0]  status
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(result_address)
                                   && $stable(status))
        else $error("stalled result changed");

    // failed and no-op requests return a null address
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != ffa_pkg::ST_OK |-> result_address == '0)
        else $error("non-null address on failed request");

    // status stays within its codes
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> status <= ffa_pkg::ST_UNKNOWN)
        else $error("bad status code");

    // an accepted request keeps the sequencer busy in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken without going busy");

endmodule

bind first_fit_heap_allocator ffa_checker u_ffa_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .result_address (result_address),
    .status         (status)
);

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for the first-fit heap allocator
// Runs a short table of directed requests and then random phases under
// several heap limits. Results are checked against a block-table predictor,
// or against the row's own expected result for typed directed rows, and both
// channels see random idle and stall patterns.
module tb;

    localparam int PERIOD      = 20;
    localparam int IDLE_LIMIT  = 5000;   // cycles without any handshake
    localparam int DRAIN_WAIT  = 300;    // wait after the final drain
    localparam int PHASE_ITEMS = 390;
    localparam int NUM_PHASES  = 5;
    localparam int NUM_ROWS    = 18;

    typedef struct packed {
        logic        op;
        logic [16:0] size;
        logic [15:0] addr;
        logic        typed;     // expected result given in the row
        logic [15:0] exp_addr;
        logic [2:0]  exp_status;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    logic        operation = ffa_pkg::OP_ALLOC;
    logic [16:0] request_size = '0;
    logic [15:0] payload_address = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    logic [15:0] result_address;
    logic [2:0]  status;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [16:0] heap_limit = 17'd65536;

    first_fit_heap_allocator dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .operation      (operation),
        .request_size   (request_size),
        .payload_address(payload_address),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .result_address (result_address),
        .status         (status),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .heap_limit     (heap_limit)
    );

    always #(PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow block table: mirrors the heap as the allocator should see it
    // ------------------------------------------------------------------
    int          shadow_ofs[ffa_pkg::MAX_BLOCKS];
    int          shadow_len[ffa_pkg::MAX_BLOCKS];
    bit          shadow_free[ffa_pkg::MAX_BLOCKS];
    int          shadow_count = 0;
    int          shadow_top = 0;
    int          shadow_limit = 65536;

    ffa_pkg::result_t pending_results[$];
    int          error_count = 0;
    int          idle_cycles = 0;
    int          burst_left = 0;
    int          gap_left = 0;

    // Remove one table entry, closing the hole.
    function automatic void close_slot(input int idx);
        for (int k = idx; k + 1 < shadow_count; k++)
        begin
            shadow_ofs[k]  = shadow_ofs[k + 1];
            shadow_len[k]  = shadow_len[k + 1];
            shadow_free[k] = shadow_free[k + 1];
        end
        shadow_count--;
    endfunction

    function automatic ffa_pkg::result_t heap_allocate(input int size);
        ffa_pkg::result_t r;
        int               lim;
        int               total;
        r.address = '0;
        r.status  = ffa_pkg::ST_NOP;
        if (size == 0)
            return r;
        // first fit: lowest free block that holds the request
        for (int i = 0; i < shadow_count; i++)
        begin
            if (shadow_free[i] && shadow_len[i] >= size)
            begin
                shadow_free[i] = 1'b0;
                // split only when the remainder can carry its own header
                if (shadow_len[i] > ffa_pkg::HEADER_BYTES + size &&
                    shadow_count < ffa_pkg::MAX_BLOCKS)
                begin
                    for (int k = shadow_count; k > i + 1; k--)
                    begin
                        shadow_ofs[k]  = shadow_ofs[k - 1];
                        shadow_len[k]  = shadow_len[k - 1];
                        shadow_free[k] = shadow_free[k - 1];
                    end
                    shadow_count++;
                    shadow_ofs[i + 1]  = shadow_ofs[i] + ffa_pkg::HEADER_BYTES + size;
                    shadow_len[i + 1]  = shadow_len[i] - size - ffa_pkg::HEADER_BYTES;
                    shadow_free[i + 1] = 1'b1;
                    shadow_len[i]      = size;
                end
                r.address = 16'(shadow_ofs[i] + ffa_pkg::HEADER_BYTES);
                r.status  = ffa_pkg::ST_OK;
                return r;
            end
        end
        // no fit: grow the heap top, limit first, then table space
        lim   = shadow_limit < ffa_pkg::HEAP_BYTES ? shadow_limit : ffa_pkg::HEAP_BYTES;
        total = ffa_pkg::HEADER_BYTES + size;
        if (shadow_top > lim || total > lim - shadow_top)
        begin
            r.status = ffa_pkg::ST_NO_HEAP;
            return r;
        end
        if (shadow_count >= ffa_pkg::MAX_BLOCKS)
        begin
            r.status = ffa_pkg::ST_FULL;
            return r;
        end
        shadow_ofs[shadow_count]  = shadow_top;
        shadow_len[shadow_count]  = size;
        shadow_free[shadow_count] = 1'b0;
        shadow_count++;
        shadow_top += total;
        r.address = 16'(shadow_top - total + ffa_pkg::HEADER_BYTES);
        r.status  = ffa_pkg::ST_OK;
        return r;
    endfunction

    function automatic ffa_pkg::result_t heap_release(input int paddr);
        ffa_pkg::result_t r;
        int               i;
        r.address = '0;
        r.status  = ffa_pkg::ST_NOP;
        if (paddr == 0)
            return r;
        for (i = 0; i < shadow_count; i++)
            if (shadow_ofs[i] + ffa_pkg::HEADER_BYTES == paddr)
                break;
        if (i >= shadow_count)
        begin
            r.status = ffa_pkg::ST_UNKNOWN;
            return r;
        end
        shadow_free[i] = 1'b1;
        // merge forward, then backward
        if (i + 1 < shadow_count && shadow_free[i + 1])
        begin
            shadow_len[i] += shadow_len[i + 1] + ffa_pkg::HEADER_BYTES;
            close_slot(i + 1);
        end
        if (i > 0 && shadow_free[i - 1])
        begin
            shadow_len[i - 1] += shadow_len[i] + ffa_pkg::HEADER_BYTES;
            close_slot(i);
        end
        r.status = ffa_pkg::ST_OK;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request side: bursts of back-to-back requests with random gaps
    // ------------------------------------------------------------------
    task automatic send_request(input logic op, input logic [16:0] size,
                                input logic [15:0] addr, input bit typed,
                                input ffa_pkg::result_t typed_result);
        ffa_pkg::result_t predicted;
        while (gap_left > 0)
        begin
            @(posedge clk);
            gap_left--;
        end
        req_valid       <= 1'b1;
        operation       <= op;
        request_size    <= size;
        payload_address <= addr;
        // hold the request until the allocator takes it
        do
            @(posedge clk);
        while (req_stall);
        predicted = (op == ffa_pkg::OP_ALLOC) ? heap_allocate(int'(size))
                                              : heap_release(int'(addr));
        pending_results.push_back(typed ? typed_result : predicted);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60)
                                                   : $urandom_range(0, 6);
            gap_left   = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 12);
            if (gap_left > 0)
                req_valid <= 1'b0;
        end
    endtask

    // Drop valid and wait until every outstanding result has come back.
    task automatic drain_results();
        // a pending gap has already dropped valid
        if (req_valid && gap_left == 0)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        gap_left = 0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_heap_limit(input logic [16:0] value);
        drain_results();
        cfg_valid  <= 1'b1;
        heap_limit <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        shadow_limit = int'(value);
    endtask

    // ------------------------------------------------------------------
    // Result side: stall pattern changes mode every so often
    // ------------------------------------------------------------------
    int stall_mode = 0;
    int stall_run = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    always @(posedge clk)
    begin
        ffa_pkg::result_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result, address", result_address, -1);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result_address !== want.address)
                    report_mismatch("result_address", result_address, want.address);
                if (status !== want.status)
                    report_mismatch("status", status, want.status);
            end
        end
        if (stall_run == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_run  = $urandom_range(10, 120);
        end
        stall_run--;
        case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 1) == 0);
            default: rsp_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // Watchdog: any handshake counts as progress.
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Directed rows: no-ops, unknown address, growth, limit, split,
    // unsplit hand-out, double free and merges
    // ------------------------------------------------------------------
    stim_row_t directed_rows[NUM_ROWS] = '{
        '{ffa_pkg::OP_ALLOC, 17'd0,      16'd0,     1'b1, 16'd0,  ffa_pkg::ST_NOP},
        '{ffa_pkg::OP_FREE,  17'd0,      16'd0,     1'b1, 16'd0,  ffa_pkg::ST_NOP},
        '{ffa_pkg::OP_FREE,  17'd0,      16'd1234,  1'b1, 16'd0,  ffa_pkg::ST_UNKNOWN},
        '{ffa_pkg::OP_ALLOC, 17'd1,      16'd0,     1'b1, 16'd32, ffa_pkg::ST_OK},
        '{ffa_pkg::OP_ALLOC, 17'd100,    16'd0,     1'b1, 16'd65, ffa_pkg::ST_OK},
        '{ffa_pkg::OP_ALLOC, 17'd65536,  16'd0,     1'b1, 16'd0,  ffa_pkg::ST_NO_HEAP},
        '{ffa_pkg::OP_ALLOC, 17'd200,    16'd65535, 1'b0, 16'd0,  ffa_pkg::ST_OK},
        '{ffa_pkg::OP_FREE,  17'd131071, 16'd65,    1'b1, 16'd0,  ffa_pkg::ST_OK},
        '{ffa_pkg::OP_FREE,  17'd0,      16'd65,    1'b1, 16'd0,  ffa_pkg::ST_OK},
        '{ffa_pkg::OP_ALLOC, 17'd10,     16'd0,     1'b0, 16'd0,  ffa_pkg::ST_OK},
        '{ffa_pkg::OP_ALLOC, 17'd50,     16'd0,     1'b0, 16'd0,  ffa_pkg::ST_OK},
        '{ffa_pkg::OP_FREE,  17'd0,      16'd32,    1'b0, 16'd0,  ffa_pkg::ST_OK},
        '{ffa_pkg::OP_FREE,  17'd0,      16'd65,    1'b0, 16'd0,  ffa_pkg::ST_OK},
        '{ffa_pkg::OP_FREE,  17'd0,      16'd197,   1'b0, 16'd0,  ffa_pkg::ST_OK},
        '{ffa_pkg::OP_FREE,  17'd0,      16'd107,   1'b0, 16'd0,  ffa_pkg::ST_OK},
        '{ffa_pkg::OP_ALLOC, 17'd131071, 16'd0,     1'b1, 16'd0,  ffa_pkg::ST_NO_HEAP},
        '{ffa_pkg::OP_FREE,  17'd0,      16'd65535, 1'b1, 16'd0,  ffa_pkg::ST_UNKNOWN},
        '{ffa_pkg::OP_ALLOC, 17'd397,    16'd0,     1'b0, 16'd0,  ffa_pkg::ST_OK}
    };

    logic [16:0] phase_limits[NUM_PHASES];

    initial
    begin
        ffa_pkg::result_t typed_res;
        logic             op;
        logic [16:0]      size;
        logic [15:0]      addr;
        int               pick;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < NUM_ROWS; r++)
        begin
            typed_res.address = directed_rows[r].exp_addr;
            typed_res.status  = directed_rows[r].exp_status;
            send_request(directed_rows[r].op, directed_rows[r].size, directed_rows[r].addr,
                         directed_rows[r].typed, typed_res);
        end

        phase_limits = '{17'd0, 17'd131071, 17'(4096 + $urandom_range(0, 8192)),
                         17'd2000, 17'd65536};

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_heap_limit(phase_limits[p]);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // hold off once per phase until the result side is empty
                if (n == PHASE_ITEMS / 3)
                    drain_results();
                pick = $urandom_range(0, 99);
                op   = (pick < 50) ? ffa_pkg::OP_ALLOC : ffa_pkg::OP_FREE;
                size = 17'($urandom);
                addr = 16'($urandom);
                if (op == ffa_pkg::OP_ALLOC)
                begin
                    case ($urandom_range(0, 19))
                        0:       size = '0;
                        1:       ;                               // full-range size
                        2, 3:    size = 17'($urandom_range(1, 4000));
                        default: size = 17'($urandom_range(1, 300));
                    endcase
                end
                else if (pick < 92 && shadow_count > 0)
                begin
                    // mostly free a real block, sometimes an already free one
                    addr = 16'(shadow_ofs[$urandom_range(0, shadow_count - 1)]
                               + ffa_pkg::HEADER_BYTES);
                end
                else if (pick < 95)
                begin
                    addr = '0;
                end
                send_request(op, size, addr, 1'b0, typed_res);
            end
        end

        drain_results();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ffa_pkg.sv
rtl/ffa_ram.sv
rtl/ffa_ctrl.sv
rtl/first_fit_heap_allocator.sv
rtl/ffa_checker.sv
tb/tb.sv
